// ----- hw/rtl/sem_pkg.sv -----
// Shared constants for the Sobel edge magnitude block.
package sem_pkg;

	localparam int PIX_W      = 8;
	localparam int COORD_W    = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CFG_DATA_W-1:0] RESET_SIZE = 13'd256;

	// magnitude squared at or above 255*255 saturates
	localparam logic [20:0] SAT_SQ = 21'd65025;

endpackage

// ----- hw/rtl/sem_pix_if.sv -----
// Pixel input channel.
interface sem_pix_if import sem_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink   (input valid, input pixel_value, output ready);
endinterface

// ----- hw/rtl/sem_res_if.sv -----
// Edge result output channel.
interface sem_res_if import sem_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   edge_value;
	logic [COORD_W-1:0] out_col;
	logic [COORD_W-1:0] out_row;
	logic               run_last;

	modport source (output valid, output edge_value, output out_col, output out_row,
		output run_last, input ready);
	modport sink   (input valid, input edge_value, input out_col, input out_row,
		input run_last, output ready);
endinterface

// ----- hw/rtl/sem_cfg_if.sv -----
// Configuration register write channel.
interface sem_cfg_if import sem_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/sobel_edge_magnitude_top.sv -----
// Streaming 3x3 Sobel edge magnitude with a single-port line store.
// Per pixel: S_CALC, S_SQ, S_ROOT, then S_EMIT loads results into the output register.
// Pace: a pixel is taken only in S_IDLE, after all results load (on res.ready);
//   set by the 8-step bit-serial square root and the line store read-modify-write.
// Reset: counters and window clear, frame size 256x256; the line store is not cleared.
module sobel_edge_magnitude_top import sem_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input logic     clk,
	input logic     arst_n,
	sem_pix_if.sink   pix,
	sem_res_if.source res,
	sem_cfg_if.sink   cfg
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WBA = $clog2(MAX_WIDTH + 1);
	localparam int HBA = $clog2(MAX_HEIGHT + 1);
	localparam int WB  = (WBA > CFG_DATA_W) ? WBA : CFG_DATA_W;
	localparam int HB  = (HBA > CFG_DATA_W) ? HBA : CFG_DATA_W;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CALC = 5'b00010,
		S_SQ   = 5'b00100,
		S_ROOT = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t state_q;

	logic [CFG_DATA_W-1:0] width_q, height_q;
	logic [CW-1:0]         col_q, c_q, w1_q;
	logic [RW-1:0]         row_q, r_q, h1_q;
	logic [PIX_W-1:0]      pix_q;
	logic [15:0]           rd_q;
	logic [47:0]           window_q;
	logic [10:0]           ax_q, ay_q;
	logic [20:0]           sum_q;
	logic [7:0]            root_q, bit_q;
	logic                  interior_q;
	logic [2:0]            pend_q;
	logic                  res_valid_q, res_last_q;
	logic [PIX_W-1:0]      res_edge_q;
	logic [COORD_W-1:0]    res_col_q, res_row_q;

	logic [15:0] line_mem [0:MAX_WIDTH-1];

	// size clamp and position clamp
	logic [WB-1:0] w_ext, w_cl, col_ext, w1_ext;
	logic [HB-1:0] h_ext, h_cl, row_ext, h1_ext;
	logic [CW-1:0] w1_d, c_d;
	logic [RW-1:0] h1_d, r_d;
	logic          accept;

	assign w_ext   = WB'(width_q);
	assign h_ext   = HB'(height_q);
	assign w_cl    = (w_ext < WB'(3)) ? WB'(3) : (w_ext > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : w_ext;
	assign h_cl    = (h_ext < HB'(3)) ? HB'(3)
		: (h_ext > HB'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT) : h_ext;
	assign w1_ext  = w_cl - WB'(1);
	assign h1_ext  = h_cl - HB'(1);
	assign w1_d    = w1_ext[CW-1:0];
	assign h1_d    = h1_ext[RW-1:0];
	assign col_ext = WB'(col_q);
	assign row_ext = HB'(row_q);
	assign c_d     = (col_ext > w1_ext) ? w1_d : col_q;
	assign r_d     = (row_ext > h1_ext) ? h1_d : row_q;

	assign pix.ready = (state_q == S_IDLE);
	assign accept    = pix.valid && pix.ready;
	assign cfg.ready = 1'b1;

	// gradient
	logic [7:0]  t_r, m_r, b_r, t_c, b_c, t_l, m_l, b_l;
	logic [9:0]  sx_r, sx_l, sy_t, sy_b;
	logic [11:0] gx, gy, gx_abs, gy_abs;
	logic [23:0] cur;

	assign cur    = {rd_q, pix_q};
	assign t_r    = rd_q[15:8];
	assign m_r    = rd_q[7:0];
	assign b_r    = pix_q;
	assign t_c    = window_q[23:16];
	assign b_c    = window_q[7:0];
	assign t_l    = window_q[47:40];
	assign m_l    = window_q[39:32];
	assign b_l    = window_q[31:24];
	assign sx_r   = 10'(t_r) + {1'b0, m_r, 1'b0} + 10'(b_r);
	assign sx_l   = 10'(t_l) + {1'b0, m_l, 1'b0} + 10'(b_l);
	assign sy_t   = 10'(t_l) + {1'b0, t_c, 1'b0} + 10'(t_r);
	assign sy_b   = 10'(b_l) + {1'b0, b_c, 1'b0} + 10'(b_r);
	assign gx     = {2'b00, sx_r} - {2'b00, sx_l};
	assign gy     = {2'b00, sy_t} - {2'b00, sy_b};
	assign gx_abs = gx[11] ? (12'd0 - gx) : gx;
	assign gy_abs = gy[11] ? (12'd0 - gy) : gy;

	logic [21:0] sqx, sqy;
	logic [20:0] sum_d;
	assign sqx   = ax_q * ax_q;
	assign sqy   = ay_q * ay_q;
	assign sum_d = 21'(sqx + sqy);

	logic [7:0]  cand;
	logic [15:0] cand_sq;
	assign cand    = root_q | bit_q;
	assign cand_sq = cand * cand;

	// result selection
	logic [2:0]          pick;
	logic                pick_last, out_load;
	logic [PIX_W-1:0]    mag, pick_edge;
	logic [CW-1:0]       pick_col;
	logic [RW-1:0]       pick_row;
	logic [CW+COORD_W-1:0] col_wide;
	logic [RW+COORD_W-1:0] row_wide;

	assign mag = !interior_q ? 8'd0 : (sum_q >= SAT_SQ) ? 8'd255 : root_q;

	always_comb begin
		pick      = 3'b000;
		pick_edge = 8'd0;
		pick_col  = c_q;
		pick_row  = h1_q;
		case (1'b1)
			pend_q[0]: begin
				pick      = 3'b001;
				pick_edge = mag;
				pick_col  = c_q - CW'(1);
				pick_row  = r_q - RW'(1);
			end
			pend_q[1]: begin
				pick     = 3'b010;
				pick_col = w1_q;
				pick_row = r_q - RW'(1);
			end
			pend_q[2]: begin
				pick = 3'b100;
			end
			default: begin
				pick = 3'b000;
			end
		endcase
	end

	assign pick_last = ((pend_q & ~pick) == 3'b000);
	assign out_load  = (state_q == S_EMIT) && (pend_q != 3'b000) && (!res_valid_q || res.ready);
	assign col_wide  = (CW+COORD_W)'(pick_col);
	assign row_wide  = (RW+COORD_W)'(pick_row);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_SIZE;
			height_q <= RESET_SIZE;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FRAME_WIDTH:  width_q  <= cfg.data;
				REG_FRAME_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= line_mem[c_d];
		end
		if (state_q == S_CALC) begin
			line_mem[c_q] <= {rd_q[7:0], pix_q};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			window_q    <= '0;
			pend_q      <= 3'b000;
			res_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					window_q <= {window_q[23:0], cur};
					pend_q   <= {r_q == h1_q, (r_q != '0) && (c_q == w1_q),
						(r_q != '0) && (c_q != '0)};
					if (c_q == w1_q) begin
						col_q <= '0;
						row_q <= (r_q == h1_q) ? '0 : r_q + RW'(1);
					end else begin
						col_q <= c_q + CW'(1);
						row_q <= r_q;
					end
					state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (bit_q[0]) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (pend_q == 3'b000) begin
						state_q <= S_IDLE;
					end else if (out_load) begin
						pend_q <= pend_q & ~pick;
						if (pick_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pix.pixel_value;
			c_q   <= c_d;
			r_q   <= r_d;
			w1_q  <= w1_d;
			h1_q  <= h1_d;
		end
		if (state_q == S_CALC) begin
			ax_q       <= gx_abs[10:0];
			ay_q       <= gy_abs[10:0];
			interior_q <= (r_q >= RW'(2)) && (c_q >= CW'(2));
		end
		if (state_q == S_SQ) begin
			sum_q  <= sum_d;
			root_q <= 8'd0;
			bit_q  <= 8'h80;
		end
		if (state_q == S_ROOT) begin
			if ({5'd0, cand_sq} <= sum_q) begin
				root_q <= cand;
			end
			bit_q <= bit_q >> 1;
		end
		if (out_load) begin
			res_edge_q <= pick_edge;
			res_col_q  <= col_wide[COORD_W-1:0];
			res_row_q  <= row_wide[COORD_W-1:0];
			res_last_q <= pick_last;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.edge_value = res_edge_q;
	assign res.out_col    = res_col_q;
	assign res.out_row    = res_row_q;
	assign res.run_last   = res_last_q;

	a_accept_calc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_CALC)
		else $error("accepted transaction did not start the line store update");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> pend_q == 3'b000)
		else $error("results left pending at idle");

	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROOT |-> $onehot(bit_q))
		else $error("square root step mask corrupt");

	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.edge_value != 8'd0 |-> res.out_col != '0 && res.out_row != '0)
		else $error("nonzero edge on first row or column");

	a_root_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROOT && bit_q[0] |=> state_q == S_EMIT)
		else $error("square root did not finish after eight steps");

endmodule
